// ===== hw/rtl/c2s_pkg.sv =====
// Shared constants and the CORDIC arctangent table for the Cartesian to
// spherical converter. No dependencies.
package c2s_pkg;

    localparam int FRAC_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 18;

    localparam int IN_W       = 32;
    localparam int AZ_W       = 19;
    localparam int EL_W       = 18;
    localparam int DIST_W     = 32;
    localparam int CFG_W      = 16;
    localparam int SQ_W       = 64;   // sum of squares
    localparam int SQRT_STEPS = 32;   // one result bit per step
    localparam int CW         = 52;   // CORDIC x/y datapath
    localparam int ZW         = 36;   // Q30 angle accumulator
    localparam int GUARD_BITS = 16;   // CORDIC input pre-scale

    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518852;

    // atan(2^-i), radians Q30, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:  v = 36'sd843314857;
            5'd1:  v = 36'sd497837829;
            5'd2:  v = 36'sd263043837;
            5'd3:  v = 36'sd133525159;
            5'd4:  v = 36'sd67021687;
            5'd5:  v = 36'sd33543516;
            5'd6:  v = 36'sd16775851;
            5'd7:  v = 36'sd8388437;
            5'd8:  v = 36'sd4194283;
            5'd9:  v = 36'sd2097149;
            5'd10: v = 36'sd1048576;
            5'd11: v = 36'sd524288;
            5'd12: v = 36'sd262144;
            5'd13: v = 36'sd131072;
            5'd14: v = 36'sd65536;
            5'd15: v = 36'sd32768;
            5'd16: v = 36'sd16384;
            5'd17: v = 36'sd8192;
            5'd18: v = 36'sd4096;
            5'd19: v = 36'sd2048;
            5'd20: v = 36'sd1024;
            5'd21: v = 36'sd512;
            5'd22: v = 36'sd256;
            5'd23: v = 36'sd128;
            5'd24: v = 36'sd64;
            5'd25: v = 36'sd32;
            5'd26: v = 36'sd16;
            5'd27: v = 36'sd8;
            5'd28: v = 36'sd4;
            5'd29: v = 36'sd2;
            5'd30: v = 36'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/cartesian_to_spherical_top.sv =====
// Cartesian to spherical converter: streaming top level, fully pipelined.
// Depends on c2s_pkg.
//
// Usage notes
// - Slave stream carries one point per transaction: x, y, z in signed Q15.16.
// - Master stream returns one transaction per point: azimuth, elevation
//   (radians, FRAC_BITS fractional bits) and distance (Q16.16).
// - Config channel writes near_zero_limit (unsigned Q0.16); ready is always high.
//   Write it only while the pipeline is empty.
// - Throughput: one point per clock unless stalled. Stages: input register,
//   squaring, two adds, 32 square-root steps (one result bit each), CORDIC
//   pre-rotation, CORDIC_STAGES micro-rotations and a rounding/clamp output
//   stage.
// - Azimuth and elevation CORDICs run side by side; the azimuth operands
//   ride along the square-root pipeline to stay aligned.
// - Stall: the whole pipeline holds on one shared enable while the output
//   register is full and the receiver is not ready; nothing is lost.
// - Reset (synchronous, active low) clears all valid bits and the limit.
module cartesian_to_spherical_top
    import c2s_pkg::*;
#(
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // slave stream
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [95:0]      s_axis_tdata,   // x_coord, y_coord, z_coord
    // master stream
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // azimuth, elevation, distance, pad
    // config write
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int SH = 30 - FRAC_BITS;
    localparam logic signed [ZW-1:0] RND = (SH == 0) ? '0 : (ZW'(1) <<< (SH - 1));
    localparam logic signed [ZW-1:0] AZ_LIM = (PI_Q30 + RND) >>> SH;
    localparam logic signed [ZW-1:0] EL_LIM = (HALF_PI_Q30 + RND) >>> SH;

    logic en;
    logic [CFG_W-1:0] r_limit;

    // ---------------- config ----------------
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    // ---------------- stall control ----------------
    logic r_ov;
    assign en            = !r_ov || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_ov;

    // ---------------- input, squares, sums ----------------
    logic r_v0, r_v1, r_v2;
    logic signed [IN_W-1:0] r_x0, r_y0, r_z0, r_x1, r_y1, r_z1, r_x2, r_y2, r_z2;
    logic [IN_W-1:0] ax, ay, az;
    logic [SQ_W-1:0] r_sqx, r_sqy, r_sqz, r_sxy, r_sqz2;

    assign ax = r_x0[IN_W-1] ? IN_W'(-r_x0) : IN_W'(r_x0);
    assign ay = r_y0[IN_W-1] ? IN_W'(-r_y0) : IN_W'(r_y0);
    assign az = r_z0[IN_W-1] ? IN_W'(-r_z0) : IN_W'(r_z0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v0 <= s_axis_tvalid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x0   <= s_axis_tdata[31:0];
            r_y0   <= s_axis_tdata[63:32];
            r_z0   <= s_axis_tdata[95:64];
            r_sqx  <= SQ_W'(ax) * SQ_W'(ax);
            r_sqy  <= SQ_W'(ay) * SQ_W'(ay);
            r_sqz  <= SQ_W'(az) * SQ_W'(az);
            r_x1   <= r_x0;
            r_y1   <= r_y0;
            r_z1   <= r_z0;
            r_sxy  <= r_sqx + r_sqy;
            r_sqz2 <= r_sqz;
            r_x2   <= r_x1;
            r_y2   <= r_y1;
            r_z2   <= r_z1;
        end
    end

    // ---------------- square roots, one bit per stage ----------------
    // d*: full distance, q*: length in the xy plane
    logic            r_sv [0:SQRT_STEPS];
    logic [SQ_W-1:0] r_dv [0:SQRT_STEPS];
    logic [SQ_W-1:0] r_dr [0:SQRT_STEPS];
    logic [SQ_W-1:0] r_qv [0:SQRT_STEPS];
    logic [SQ_W-1:0] r_qr [0:SQRT_STEPS];
    logic signed [IN_W-1:0] r_sx [0:SQRT_STEPS];
    logic signed [IN_W-1:0] r_sy [0:SQRT_STEPS];
    logic signed [IN_W-1:0] r_sz [0:SQRT_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (en) begin
            r_sv[0] <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv[0] <= r_sxy + r_sqz2;
            r_dr[0] <= '0;
            r_qv[0] <= r_sxy;
            r_qr[0] <= '0;
            r_sx[0] <= r_x2;
            r_sy[0] <= r_y2;
            r_sz[0] <= r_z2;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (62 - 2 * k);
        logic [SQ_W-1:0] dt, qt;
        assign dt = r_dr[k] + BIT;
        assign qt = r_qr[k] + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else if (en) begin
                r_sv[k+1] <= r_sv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_dv[k] >= dt) begin
                    r_dv[k+1] <= r_dv[k] - dt;
                    r_dr[k+1] <= (r_dr[k] >> 1) + BIT;
                end else begin
                    r_dv[k+1] <= r_dv[k];
                    r_dr[k+1] <= r_dr[k] >> 1;
                end
                if (r_qv[k] >= qt) begin
                    r_qv[k+1] <= r_qv[k] - qt;
                    r_qr[k+1] <= (r_qr[k] >> 1) + BIT;
                end else begin
                    r_qv[k+1] <= r_qv[k];
                    r_qr[k+1] <= r_qr[k] >> 1;
                end
                r_sx[k+1] <= r_sx[k];
                r_sy[k+1] <= r_sy[k];
                r_sz[k+1] <= r_sz[k];
            end
        end
    end

    // ---------------- CORDIC pre-rotation ----------------
    logic                   r_cv   [0:CORDIC_STAGES];
    logic                   r_zero [0:CORDIC_STAGES];
    logic [DIST_W-1:0]      r_dist [0:CORDIC_STAGES];
    logic signed [CW-1:0]   r_ax   [0:CORDIC_STAGES];
    logic signed [CW-1:0]   r_ay   [0:CORDIC_STAGES];
    logic signed [ZW-1:0]   r_az   [0:CORDIC_STAGES];
    logic signed [CW-1:0]   r_ex   [0:CORDIC_STAGES];
    logic signed [CW-1:0]   r_ey   [0:CORDIC_STAGES];
    logic signed [ZW-1:0]   r_ez   [0:CORDIC_STAGES];

    logic signed [CW-1:0] px, py, pz;
    assign px = CW'(r_sx[SQRT_STEPS]) <<< GUARD_BITS;
    assign py = CW'(r_sy[SQRT_STEPS]) <<< GUARD_BITS;
    assign pz = CW'(r_sz[SQRT_STEPS]) <<< GUARD_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (en) begin
            r_cv[0] <= r_sv[SQRT_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zero[0] <= (r_sx[SQRT_STEPS] == '0) && (r_sy[SQRT_STEPS] == '0);
            r_dist[0] <= r_dr[SQRT_STEPS][DIST_W-1:0];
            if (px < 0) begin
                if (py >= 0) begin
                    r_ax[0] <= py;
                    r_ay[0] <= -px;
                    r_az[0] <= HALF_PI_Q30;
                end else begin
                    r_ax[0] <= -py;
                    r_ay[0] <= px;
                    r_az[0] <= -HALF_PI_Q30;
                end
            end else begin
                r_ax[0] <= px;
                r_ay[0] <= py;
                r_az[0] <= '0;
            end
            // xy length is never negative: no pre-rotation
            r_ex[0] <= CW'({1'b0, r_qr[SQRT_STEPS][DIST_W-1:0]}) <<< GUARD_BITS;
            r_ey[0] <= pz;
            r_ez[0] <= '0;
        end
    end

    // ---------------- CORDIC micro-rotations ----------------
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        localparam logic signed [ZW-1:0] ANG = atan_q30(5'(i));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[i+1] <= 1'b0;
            end else if (en) begin
                r_cv[i+1] <= r_cv[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_zero[i+1] <= r_zero[i];
                r_dist[i+1] <= r_dist[i];
                if (r_ay[i] >= 0) begin
                    r_ax[i+1] <= r_ax[i] + (r_ay[i] >>> i);
                    r_ay[i+1] <= r_ay[i] - (r_ax[i] >>> i);
                    r_az[i+1] <= r_az[i] + ANG;
                end else begin
                    r_ax[i+1] <= r_ax[i] - (r_ay[i] >>> i);
                    r_ay[i+1] <= r_ay[i] + (r_ax[i] >>> i);
                    r_az[i+1] <= r_az[i] - ANG;
                end
                if (r_ey[i] >= 0) begin
                    r_ex[i+1] <= r_ex[i] + (r_ey[i] >>> i);
                    r_ey[i+1] <= r_ey[i] - (r_ex[i] >>> i);
                    r_ez[i+1] <= r_ez[i] + ANG;
                end else begin
                    r_ex[i+1] <= r_ex[i] - (r_ey[i] >>> i);
                    r_ey[i+1] <= r_ey[i] + (r_ex[i] >>> i);
                    r_ez[i+1] <= r_ez[i] - ANG;
                end
            end
        end
    end

    // ---------------- offset, wrap, round, clamp ----------------
    logic signed [ZW-1:0] az_a, az_w, az_r, az_c, el_r, el_c;
    logic [AZ_W-1:0]   r_oaz;
    logic [EL_W-1:0]   r_oel;
    logic [DIST_W-1:0] r_odist;

    always_comb begin
        az_a = (r_zero[CORDIC_STAGES] ? '0 : r_az[CORDIC_STAGES]) - HALF_PI_Q30;
        az_w = (az_a < -PI_Q30) ? az_a + TWO_PI_Q30 : az_a;
        az_r = (az_w + RND) >>> SH;
        if (az_r > AZ_LIM) begin
            az_c = AZ_LIM;
        end else if (az_r < -AZ_LIM) begin
            az_c = -AZ_LIM;
        end else begin
            az_c = az_r;
        end
        el_r = (r_ez[CORDIC_STAGES] + RND) >>> SH;
        if (r_dist[CORDIC_STAGES] <= DIST_W'(r_limit)) begin
            el_c = '0;
        end else if (el_r > EL_LIM) begin
            el_c = EL_LIM;
        end else if (el_r < -EL_LIM) begin
            el_c = -EL_LIM;
        end else begin
            el_c = el_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_cv[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_oaz   <= az_c[AZ_W-1:0];
            r_oel   <= el_c[EL_W-1:0];
            r_odist <= r_dist[CORDIC_STAGES];
        end
    end

    assign m_axis_tdata = {3'b000, r_odist, r_oel, r_oaz};

endmodule

// ===== verif/cartesian_to_spherical_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the Cartesian to spherical converter: random and directed points
// with a self-contained fixed-point predictor and a small in-order scoreboard.
// Depends on c2s_pkg and cartesian_to_spherical_top.
class c2s_scoreboard;
    typedef struct {
        logic signed [c2s_pkg::AZ_W-1:0] az;
        logic signed [c2s_pkg::EL_W-1:0] el;
        logic [c2s_pkg::DIST_W-1:0]      rng;
    } t_polar;

    // atan(2^-i) in radians, Q30
    localparam longint ATAN_TAB [18] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192};
    localparam longint Q30_HALF_PI = 64'sd1686629713;
    localparam longint Q30_PI      = 64'sd3373259426;
    localparam longint Q30_TWO_PI  = 64'sd6746518852;

    t_polar      pending[$];
    logic [15:0] limit;
    int          errors;
    int          mismatches;
    int          checked;

    function new();
        limit      = '0;
        errors     = 0;
        mismatches = 0;
        checked    = 0;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function longint vector_angle(longint yv, longint xv);
        longint x, y, z, t, nx, ny;
        z = 0;
        if (xv == 0 && yv == 0) return 0;
        x = xv * 65536;
        y = yv * 65536;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = Q30_HALF_PI;
            end else begin
                x = -y; y = t; z = -Q30_HALF_PI;
            end
        end
        for (int i = 0; i < 18; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + ATAN_TAB[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - ATAN_TAB[i];
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    function longint round_q16(longint v);
        return (v + 8192) >>> 14;
    endfunction

    function longint clamp(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function void note_point(logic [31:0] xr, logic [31:0] yr, logic [31:0] zr);
        longint x, y, z, azim, elev;
        longint unsigned ax, ay, az, sxy, dlen, rxy;
        t_polar p;
        x = longint'($signed(xr));
        y = longint'($signed(yr));
        z = longint'($signed(zr));
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        sxy  = ax * ax + ay * ay;
        dlen = int_sqrt(sxy + az * az);
        rxy  = int_sqrt(sxy);
        azim = vector_angle(y, x) - Q30_HALF_PI;
        if (azim < -Q30_PI) azim = azim + Q30_TWO_PI;
        azim = clamp(round_q16(azim), round_q16(Q30_PI));
        if (dlen <= limit) elev = 0;
        else elev = clamp(round_q16(vector_angle(z, longint'(rxy))),
                          round_q16(Q30_HALF_PI));
        p.az  = azim[18:0];
        p.el  = elev[17:0];
        p.rng = dlen[31:0];
        pending.push_back(p);
    endfunction

    function void check_result(logic [71:0] td);
        t_polar e;
        checked++;
        if (pending.size() == 0) begin
            errors++;
            if (mismatches++ < 10) $display("unexpected result tdata=%h", td);
            return;
        end
        e = pending.pop_front();
        if (td[18:0] !== e.az || td[36:19] !== e.el || td[68:37] !== e.rng) begin
            errors++;
            if (mismatches++ < 10)
                $display("mismatch #%0d: az %0d/%0d el %0d/%0d dist %0d/%0d (exp/act)",
                         checked, e.az, $signed(td[18:0]), e.el, $signed(td[36:19]),
                         e.rng, td[68:37]);
        end
    endfunction
endclass

module cartesian_to_spherical_top_tb;
    import c2s_pkg::*;

    localparam int LATENCY   = 56;
    localparam int MAX_CYCLE = 600000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;   // x_coord, y_coord, z_coord
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // azimuth, elevation, distance, pad
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    c2s_scoreboard sb;
    int send_gap_max;     // sender idle bound for the current phase
    int recv_gap_max;     // receiver idle bound
    int recv_hold;        // one long receiver hold-off, in cycles
    int points_sent;
    int cycle_count;

    cartesian_to_spherical_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > MAX_CYCLE) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Offer one point; valid stays high across back-to-back transactions.
    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_point(x, y, z);
        points_sent++;
    endtask

    task automatic idle_sender();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Pipeline drained: nothing outstanding, then the latency once more.
    task automatic drain();
        idle_sender();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.limit = value;
    endtask

    function automatic logic [31:0] rand_coord();
        int kind;
        logic [31:0] v;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3: v = $urandom();
            4:          v = $urandom_range(0, 262143) - 131072;
            5:          v = '0;
            6: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0001;
                    3: v = 32'hFFFF_FFFF;
                    default: v = '0;
                endcase
            end
            7:          v = $urandom_range(0, 600) - 300;
            default:    v = $urandom_range(0, 2097151) - 1048576;
        endcase
        return v;
    endfunction

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++)
            send_point(rand_coord(), rand_coord(), rand_coord());
    endtask

    // Receiver: random readiness, plus one long hold-off on request.
    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = $urandom_range(0, recv_gap_max);
            if (recv_hold > 0) begin
                gap = recv_hold;
                recv_hold = 0;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata);
        end
    end

    initial begin
        sb            = new();
        points_sent   = 0;
        send_gap_max  = 14;
        recv_gap_max  = 14;
        recv_hold     = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: origin, axes, quadrants, extremes, lower wrap
        send_point(32'h0, 32'h0, 32'h0);                 // origin: elevation zero
        send_point(32'h0, 32'h0, 32'h0001_0000);         // zero xy, z up
        send_point(32'h0, 32'h0, 32'hFFFF_0000);         // zero xy, z down
        send_point(32'h0001_0000, 32'h0, 32'h0);
        send_point(32'hFFFF_0000, 32'h0, 32'h0);         // negative x axis
        send_point(32'h0, 32'h0001_0000, 32'h0);
        send_point(32'h0, 32'hFFFF_0000, 32'h0);
        send_point(32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0); // just below -pi wrap
        send_point(32'hFFFF_0000, 32'h0000_0001, 32'h5);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h0000_0001, 32'h0, 32'h7FFF_FFFF); // near-vertical overshoot
        send_point(32'h0, 32'h0000_0001, 32'h8000_0000);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_point(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
        drain();

        // Largest limit: small points fall inside the near-zero zone
        write_limit(16'hFFFF);
        send_point(32'h0000_8000, 32'h0, 32'h0000_8000);
        send_point(32'h0000_FFFF, 32'h0, 32'h0);         // right on the limit
        send_point(32'h0001_0000, 32'h0, 32'h0001_0000);
        send_point(32'h0, 32'h0, 32'hFFFF_0001);
        send_random(400);
        drain();

        // Random limit, no idling on either side
        write_limit(16'($urandom_range(1, 65534)));
        send_gap_max = 0;
        recv_gap_max = 0;
        send_random(350);
        drain();

        // Receiver holds off while the sender keeps offering
        send_gap_max = 0;
        recv_gap_max = 14;
        recv_hold    = 400;
        send_random(200);
        send_gap_max = 14;
        drain();

        write_limit(16'h0000);
        send_random(400);
        drain();

        write_limit(16'h0001);
        send_random(380);
        drain();

        $display("%0d points converted over limits 0, 1, random and full scale,",
                 points_sent);
        $display("including a long output stall and runs with no idle cycles; %0d errors",
                 sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ===== cartesian_to_spherical_top.f =====
hw/rtl/c2s_pkg.sv
hw/rtl/cartesian_to_spherical_top.sv
verif/cartesian_to_spherical_top_tb.sv
